@@ rtl/core/strb_pkg.sv @@
`timescale 1ns / 1ps
package strb_pkg;

	localparam int unsigned NumWords = 8;
	localparam int unsigned NumRounds = 12;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_APPEND,
		ST_KEY0,
		ST_RSTATE,
		ST_RKEY,
		ST_FOLD,
		ST_SUM,
		ST_PAD,
		ST_FIN_N,
		ST_FIN_S,
		ST_OUT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		CMP_BLOCK,
		CMP_LAST,
		CMP_FOLD_N,
		CMP_FOLD_S
	} cmp_kind_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
		8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
		8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
		8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
		8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
		8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
		8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
		8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
		8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
		8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
		8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
		8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
		8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
		8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
		8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
		8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6};
		return t[x];
	endfunction

	localparam logic [63:0] LIN_ROWS [64] = '{
		64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
		64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
		64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
		64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
		64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
		64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
		64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
		64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
		64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
		64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
		64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
		64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
		64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
		64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
		64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
		64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083};

	localparam logic [511:0] ROUND_C [12] = '{
		{64'hb1085bda1ecadae9,64'hebcb2f81c0657c1f,64'h2f6a76432e45d016,64'h714eb88d7585c4fc,
		 64'h4b7ce09192676901,64'ha2422a08a460d315,64'h05767436cc744d23,64'hdd806559f2a64507},
		{64'h6fa3b58aa99d2f1a,64'h4fe39d460f70b5d7,64'hf3feea720a232b98,64'h61d55e0f16b50131,
		 64'h9ab5176b12d69958,64'h5cb561c2db0aa7ca,64'h55dda21bd7cbcd56,64'he679047021b19bb7},
		{64'hf574dcac2bce2fc7,64'h0a39fc286a3d8435,64'h06f15e5f529c1f8b,64'hf2ea7514b1297b7b,
		 64'hd3e20fe490359eb1,64'hc1c93a376062db09,64'hc2b6f443867adb31,64'h991e96f50aba0ab2},
		{64'hef1fdfb3e81566d2,64'hf948e1a05d71e4dd,64'h488e857e335c3c7d,64'h9d721cad685e353f,
		 64'ha9d72c82ed03d675,64'hd8b71333935203be,64'h3453eaa193e837f1,64'h220cbebc84e3d12e},
		{64'h4bea6bacad474799,64'h9a3f410c6ca92363,64'h7f151c1f1686104a,64'h359e35d7800fffbd,
		 64'hbfcd1747253af5a3,64'hdfff00b723271a16,64'h7a56a27ea9ea63f5,64'h601758fd7c6cfe57},
		{64'hae4faeae1d3ad3d9,64'h6fa4c33b7a3039c0,64'h2d66c4f95142a46c,64'h187f9ab49af08ec6,
		 64'hcffaa6b71c9ab7b4,64'h0af21f66c2bec6b6,64'hbf71c57236904f35,64'hfa68407a46647d6e},
		{64'hf4c70e16eeaac5ec,64'h51ac86febf240954,64'h399ec6c7e6bf87c9,64'hd3473e33197a93c9,
		 64'h0992abc52d822c37,64'h06476983284a0504,64'h3517454ca23c4af3,64'h8886564d3a14d493},
		{64'h9b1f5b424d93c9a7,64'h03e7aa020c6e4141,64'h4eb7f8719c36de1e,64'h89b4443b4ddbc49a,
		 64'hf4892bcb929b0690,64'h69d18d2bd1a5c42f,64'h36acc2355951a8d9,64'ha47f0dd4bf02e71e},
		{64'h378f5a541631229b,64'h944c9ad8ec165fde,64'h3a7d3a1b25894224,64'h3cd955b7e00d0984,
		 64'h800a440bdbb2ceb1,64'h7b2b8a9aa6079c54,64'h0e38dc92cb1f2a60,64'h7261445183235adb},
		{64'habbedea680056f52,64'h382ae548b2e4f3f3,64'h8941e71cff8a78db,64'h1fffe18a1b336103,
		 64'h9fe76702af69334b,64'h7a1e6c303b7652f4,64'h3698fad1153bb6c3,64'h74b4c7fb98459ced},
		{64'h7bcd9ed0efc889fb,64'h3002c6cd635afe94,64'hd8fa6bbbebab0761,64'h2001802114846679,
		 64'h8a1d71efea48b9ca,64'hefbacd1d7d476e98,64'hdea2594ac06fd85d,64'h6bcaa4cd81f32d1b},
		{64'h378ee767f11631ba,64'hd21380b00449b17a,64'hcda43c32bcdf1d77,64'hf82012d430219f9b,
		 64'h5d80ef9d1891cc86,64'he71da4aa88e12852,64'hfaf417d5d9b21b99,64'h48bc924af11bd720}};

endpackage

@@ rtl/core/strb_lps.sv @@
`timescale 1ns / 1ps
// One LPS pass over 512 bits: transpose bytes, substitute, linear map.
module strb_lps (
	input  logic [511:0] din,
	output logic [511:0] dout
);
	import strb_pkg::*;

	always_comb begin
		logic [63:0] w;
		logic [63:0] r;
		dout = '0;
		for (int i = 0; i < 8; i++) begin
			for (int j = 0; j < 8; j++) begin
				w[8*j +: 8] = sbox(din[64*j + 8*i +: 8]);
			end
			r = '0;
			for (int k = 0; k < 64; k++) begin
				if (w[k]) r = r ^ LIN_ROWS[63-k];
			end
			dout[64*i +: 64] = r;
		end
	end
endmodule

@@ rtl/core/streebog_hash_core.sv @@
`timescale 1ns / 1ps
// Streebog (GOST R 34.11-2012) hash core, 512- and 256-bit modes.
// Input stream s_axis: tdata = {byte_count[3:0], message_word[63:0]} (zero
// padded to 72 bits), tlast marks the end of the message. Each transfer is
// appended one byte per cycle, pausing while a full block is compressed, so
// a transfer holds the input until its bytes (count clipped at eight) are appended.
// Output stream m_axis: tdata = digest_word, tuser = digest_index, tlast on
// the eighth word. Eight words follow every message end; in 256 mode keep
// words 4..7.
// One LPS unit is shared: each compression is 25 LPS passes, one per cycle,
// then a fold into the chain value. Counter and checksum advance 64 bits
// per cycle, word by word, after each block's compression.
// The end of a message runs the pad state, the padded block's compression,
// the counter and checksum adds, then the counter and checksum folds, each
// a compression after its own setup state; eight output transfers follow.
// s_axis_tready is low while the core works or drains words; a stalled
// m_axis simply holds the current word.
// Reset clears counter, checksum and buffer and loads the 512-bit mode IV.
// A digest_256 write restarts the engine with the selected IV; write only
// while idle.
module streebog_hash_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // message_word[63:0], byte_count[67:64]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // digest_word[63:0]
	output logic [2:0]  m_axis_tuser,  // digest_index[2:0]
	output logic        m_axis_tlast
);
	import strb_pkg::*;

	ctrl_state_t state_q, state_d;
	cmp_kind_t   kind_q;
	logic         mode_q;
	logic [511:0] h_q, n_q, sig_q, buf_q, key_q, st_q, m_q;
	logic [5:0]   fill_q;
	logic [3:0]   rnd_q;
	logic [2:0]   bidx_q, oidx_q;
	logic [3:0]   bleft_q;
	logic [63:0]  word_q;
	logic         last_q;
	logic [511:0] lps_in, lps_out;
	logic [511:0] n_mix;
	logic [2:0]   aidx_q;
	logic         cn_q, cs_q;
	logic [63:0]  n_add;
	logic [64:0]  sum_n, sum_s;

	strb_lps u_lps (.din(lps_in), .dout(lps_out));

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = h_q[64*oidx_q +: 64];
	assign m_axis_tuser  = oidx_q;
	assign m_axis_tlast  = (oidx_q == 3'd7);

	// counter input of g_N: zero for the final folds
	assign n_mix = (kind_q inside {CMP_FOLD_N, CMP_FOLD_S}) ? '0 : n_q;

	// counter and checksum advance one 64-bit word per cycle, carry held
	assign n_add = (aidx_q != 3'd0) ? 64'd0 :
		(kind_q == CMP_LAST) ? 64'({fill_q, 3'b000}) : 64'd512;
	assign sum_n = {1'b0, n_q[64*aidx_q +: 64]} + {1'b0, n_add} + {64'd0, cn_q};
	assign sum_s = {1'b0, sig_q[64*aidx_q +: 64]} + {1'b0, m_q[64*aidx_q +: 64]}
		+ {64'd0, cs_q};

	always_comb begin
		case (state_q)
			ST_KEY0:   lps_in = h_q ^ n_mix;
			ST_RSTATE: lps_in = st_q;
			ST_RKEY:   lps_in = key_q ^ ROUND_C[rnd_q];
			default:   lps_in = key_q;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_axis_tvalid) state_d = ST_APPEND;
			ST_APPEND: begin
				if (bleft_q != 4'd0) begin
					if (fill_q == 6'd63) state_d = ST_KEY0;
				end else if (last_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PAD:    state_d = ST_KEY0;
			ST_KEY0:   state_d = ST_RSTATE;
			ST_RSTATE: state_d = ST_RKEY;
			ST_RKEY:   state_d = (rnd_q == 4'd11) ? ST_FOLD : ST_RSTATE;
			ST_FOLD: begin
				case (kind_q)
					CMP_BLOCK:  state_d = ST_SUM;
					CMP_LAST:   state_d = ST_SUM;
					CMP_FOLD_N: state_d = ST_FIN_S;
					default:    state_d = ST_OUT;
				endcase
			end
			ST_SUM: begin
				if (aidx_q == 3'd7) state_d = (kind_q == CMP_LAST) ? ST_FIN_N : ST_APPEND;
			end
			ST_FIN_N:  state_d = ST_KEY0;
			ST_FIN_S:  state_d = ST_KEY0;
			ST_OUT:    if (m_axis_tready && oidx_q == 3'd7) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= 1'b0;
			h_q     <= '0;
			n_q     <= '0;
			sig_q   <= '0;
			buf_q   <= '0;
			fill_q  <= '0;
			rnd_q   <= '0;
			oidx_q  <= '0;
			kind_q  <= CMP_BLOCK;
			aidx_q  <= '0;
			cn_q    <= 1'b0;
			cs_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				// restart under the new mode
				mode_q <= cfg_wdata;
				h_q    <= {64{cfg_wdata ? 8'h01 : 8'h00}};
				n_q    <= '0;
				sig_q  <= '0;
				buf_q  <= '0;
				fill_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						word_q  <= s_axis_tdata[63:0];
						bleft_q <= (s_axis_tdata[67:64] > 4'd8) ? 4'd8 : s_axis_tdata[67:64];
						bidx_q  <= '0;
						last_q  <= s_axis_tlast;
						kind_q  <= CMP_BLOCK;
					end
				end
				ST_APPEND: begin
					if (bleft_q != 4'd0) begin
						buf_q[8*fill_q +: 8] <= word_q[8*bidx_q +: 8];
						fill_q  <= fill_q + 6'd1;
						bidx_q  <= bidx_q + 3'd1;
						bleft_q <= bleft_q - 4'd1;
						if (fill_q == 6'd63) begin
							m_q    <= {word_q[8*bidx_q +: 8], buf_q[503:0]};
							kind_q <= CMP_BLOCK;
						end
					end
				end
				ST_PAD: begin
					buf_q[8*fill_q +: 8] <= 8'h01;
					m_q    <= buf_q | (512'h01 << {fill_q, 3'b000});
					kind_q <= CMP_LAST;
				end
				ST_KEY0: begin
					key_q <= lps_out;
					st_q  <= lps_out ^ m_q;
					rnd_q <= '0;
				end
				ST_RSTATE: st_q <= lps_out;
				ST_RKEY: begin
					key_q <= lps_out;
					st_q  <= st_q ^ lps_out;
					rnd_q <= rnd_q + 4'd1;
				end
				ST_FOLD: begin
					h_q    <= h_q ^ st_q ^ m_q;
					rnd_q  <= '0;
					aidx_q <= '0;
					cn_q   <= 1'b0;
					cs_q   <= 1'b0;
				end
				ST_SUM: begin
					n_q[64*aidx_q +: 64]   <= sum_n[63:0];
					sig_q[64*aidx_q +: 64] <= sum_s[63:0];
					cn_q   <= sum_n[64];
					cs_q   <= sum_s[64];
					aidx_q <= aidx_q + 3'd1;
					if (aidx_q == 3'd7) begin
						buf_q  <= '0;
						fill_q <= '0;
					end
				end
				ST_FIN_N: begin
					m_q    <= n_q;
					kind_q <= CMP_FOLD_N;
				end
				ST_FIN_S: begin
					m_q    <= sig_q;
					kind_q <= CMP_FOLD_S;
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							h_q   <= {64{mode_q ? 8'h01 : 8'h00}};
							n_q   <= '0;
							sig_q <= '0;
							buf_q <= '0;
							fill_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule

@@ rtl/core/strb_checker.sv @@
`timescale 1ns / 1ps
module strb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	// never take input while digest words drain
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("ready while draining");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
		else $error("tlast mismatch");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
		(m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1))
		else $error("index step");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("data not held");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
		else $error("not idle after digest");
endmodule

bind streebog_hash_core strb_checker u_strb_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
	.m_axis_tlast(m_axis_tlast)
);
